// ===== sv/absolute_encoder_odometer_defines.svh =====
// Assertion macros used by the checker file.
`ifndef ABSOLUTE_ENCODER_ODOMETER_DEFINES_SVH
`define ABSOLUTE_ENCODER_ODOMETER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define AEO_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("absolute encoder odometer check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define AEO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("absolute encoder odometer check failed");

`endif

// ===== sv/aeo_pkg.sv =====
package aeo_pkg;

    localparam int ANGLE_BITS = 14;
    localparam int LOW_BITS   = ANGLE_BITS - 8;
    localparam logic [15:0] LOW_MASK = 16'((32'd1 << LOW_BITS) - 32'd1);

    localparam int TICK_W     = 32;
    localparam int CIRC_W     = 24;
    localparam int ELAPSED_W  = 16;
    localparam int PROD_W     = TICK_W + CIRC_W;
    localparam int DMAG_W     = PROD_W - ANGLE_BITS;
    localparam int DIST_W     = DMAG_W + 1;
    localparam int DIST_OUT_W = 48;
    localparam int DIV_BITS   = DIST_W;
    localparam int DIV_CNT_W  = $clog2(DIV_BITS);

    localparam int SPEED_W = 25;
    localparam logic [SPEED_W-1:0] SPEED_MAX_CODE = {1'b0, {(SPEED_W-1){1'b1}}};
    localparam logic [SPEED_W-1:0] SPEED_MIN_CODE = {1'b1, {(SPEED_W-1){1'b0}}};
    localparam logic [DIV_BITS-1:0] SPEED_POS_LIMIT =
        {{(DIV_BITS-SPEED_W+1){1'b0}}, {(SPEED_W-1){1'b1}}};
    localparam logic [DIV_BITS-1:0] SPEED_NEG_LIMIT =
        {{(DIV_BITS-SPEED_W){1'b0}}, 1'b1, {(SPEED_W-1){1'b0}}};

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = CIRC_W;
    localparam logic [CFG_INDEX_W-1:0] REG_CIRCUMFERENCE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REVERSE       = 1'd1;

    localparam logic [CIRC_W-1:0] CIRC_RESET = 24'd1595930;

endpackage

// ===== sv/aeo_divider.sv =====
module aeo_divider
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [aeo_pkg::DIV_BITS-1:0]         dividend,
    input  logic [aeo_pkg::ELAPSED_W-1:0]        divisor,
    output logic                                 done,
    output logic [aeo_pkg::DIV_BITS-1:0]         quotient
);

    logic                                 busy_reg;
    logic                                 done_reg;
    logic [aeo_pkg::DIV_CNT_W-1:0]        cnt_reg;
    logic [aeo_pkg::DIV_BITS-1:0]         shift_reg;
    logic [aeo_pkg::ELAPSED_W-1:0]        rem_reg;
    logic [aeo_pkg::ELAPSED_W-1:0]        divisor_reg;

    logic [aeo_pkg::ELAPSED_W:0]          rem_shift;
    logic [aeo_pkg::ELAPSED_W+1:0]        trial;
    logic                                 fits;

    // One restoring step: bring down the next dividend bit, try the subtract.
    assign rem_shift = {rem_reg, shift_reg[aeo_pkg::DIV_BITS-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, divisor_reg};
    assign fits      = !trial[aeo_pkg::ELAPSED_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            shift_reg   <= '0;
            rem_reg     <= '0;
            divisor_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg    <= 1'b1;
                cnt_reg     <= '0;
                shift_reg   <= dividend;
                rem_reg     <= '0;
                divisor_reg <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg   <= fits ? trial[aeo_pkg::ELAPSED_W-1:0]
                                  : rem_shift[aeo_pkg::ELAPSED_W-1:0];
                shift_reg <= {shift_reg[aeo_pkg::DIV_BITS-2:0], fits};
                cnt_reg   <= cnt_reg + 1'b1;
                if (cnt_reg == aeo_pkg::DIV_CNT_W'(aeo_pkg::DIV_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

endmodule

// ===== sv/absolute_encoder_odometer.sv =====
// A sample passes S_MUL, S_DIST and S_DELTA; one that needs a speed divide then goes
// through S_START, S_DIV and S_SAT, the 43-step divider running in S_DIV; the priming
// sample or a zero elapsed time skips these. One sample is in flight at a time.
// in_stall is high from accept until the result is loaded into the output register.
// Reset (rst_n low, asynchronous) clears the state and loads the default config.
module absolute_encoder_odometer
(
    input  logic                                     clk,
    input  logic                                     rst_n,

    input  logic                                     cfg_we,
    input  logic [aeo_pkg::CFG_INDEX_W-1:0]          cfg_index,
    input  logic [aeo_pkg::CFG_DATA_W-1:0]           cfg_data,

    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic [7:0]                               angle_high,
    input  logic [7:0]                               angle_low,
    input  logic [aeo_pkg::ELAPSED_W-1:0]            elapsed_ms,

    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic [aeo_pkg::ANGLE_BITS-1:0]           angle,
    output logic signed [aeo_pkg::ANGLE_BITS-1:0]    movement,
    output logic signed [aeo_pkg::TICK_W-1:0]        position_ticks,
    output logic signed [aeo_pkg::DIST_OUT_W-1:0]    distance_um,
    output logic signed [aeo_pkg::SPEED_W-1:0]       speed_mm_per_s,
    output logic                                     divide_fault
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIST,
        S_DELTA,
        S_START,
        S_DIV,
        S_SAT,
        S_DONE
    } state_t;

    state_t                                state_reg;

    logic [aeo_pkg::CIRC_W-1:0]            circ_reg;
    logic                                  rev_reg;

    logic                                  primed_reg;
    logic [aeo_pkg::ANGLE_BITS-1:0]        last_angle_reg;
    logic [aeo_pkg::TICK_W-1:0]            tick_reg;
    logic [aeo_pkg::DIST_W-1:0]            prev_reg;

    logic                                  first_reg;
    logic [aeo_pkg::ANGLE_BITS-1:0]        angle_reg;
    logic [aeo_pkg::ANGLE_BITS-1:0]        move_reg;
    logic [aeo_pkg::ELAPSED_W-1:0]         ms_reg;
    logic [aeo_pkg::PROD_W-1:0]            prod_reg;
    logic                                  neg_reg;
    logic [aeo_pkg::DIST_W-1:0]            dist_reg;
    logic [aeo_pkg::DIST_W:0]              delta_reg;
    logic [aeo_pkg::SPEED_W-1:0]           speed_reg;
    logic                                  fault_reg;

    logic                                  out_valid_reg;
    logic [aeo_pkg::ANGLE_BITS-1:0]        out_angle_reg;
    logic [aeo_pkg::ANGLE_BITS-1:0]        out_move_reg;
    logic [aeo_pkg::TICK_W-1:0]            out_tick_reg;
    logic [aeo_pkg::DIST_W-1:0]            out_dist_reg;
    logic [aeo_pkg::SPEED_W-1:0]           out_speed_reg;
    logic                                  out_fault_reg;

    logic [15:0]                           angle_wide;
    logic [aeo_pkg::ANGLE_BITS-1:0]        angle_new;
    logic [aeo_pkg::ANGLE_BITS-1:0]        angle_diff;
    logic [aeo_pkg::TICK_W-1:0]            tick_mag;
    logic [aeo_pkg::DIST_W-1:0]            dist_pos;
    logic [aeo_pkg::DIST_W-1:0]            dist_val;
    logic [aeo_pkg::DIST_W:0]              delta_val;
    logic [aeo_pkg::DIST_W:0]              delta_abs;
    logic [aeo_pkg::DIV_BITS-1:0]          quotient;
    logic [aeo_pkg::SPEED_W-1:0]           q_low;
    logic [aeo_pkg::SPEED_W-1:0]           speed_val;
    logic                                  div_start;
    logic                                  div_done;
    logic                                  in_take;
    logic                                  out_free;

    assign in_take  = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign angle_wide = (16'(angle_high) << aeo_pkg::LOW_BITS)
                      | (16'(angle_low) & aeo_pkg::LOW_MASK);
    assign angle_new  = angle_wide[aeo_pkg::ANGLE_BITS-1:0];
    // Modular difference; its top bit set reads as a backward move, half a turn included.
    assign angle_diff = angle_new - last_angle_reg;

    // Multiply magnitudes so the shift truncates toward zero; sign goes back after.
    assign tick_mag = tick_reg[aeo_pkg::TICK_W-1] ? ('0 - tick_reg) : tick_reg;
    assign dist_pos = {1'b0, prod_reg[aeo_pkg::PROD_W-1:aeo_pkg::ANGLE_BITS]};
    assign dist_val = neg_reg ? ('0 - dist_pos) : dist_pos;

    assign delta_val = {dist_reg[aeo_pkg::DIST_W-1], dist_reg}
                     - {prev_reg[aeo_pkg::DIST_W-1], prev_reg};
    assign delta_abs = delta_reg[aeo_pkg::DIST_W] ? ('0 - delta_reg) : delta_reg;

    assign div_start = (state_reg == S_START);

    aeo_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (delta_abs[aeo_pkg::DIV_BITS-1:0]),
        .divisor  (ms_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Clamp the quotient magnitude, then apply the sign of the distance change.
    assign q_low = quotient[aeo_pkg::SPEED_W-1:0];
    always_comb
    begin
        if (delta_reg[aeo_pkg::DIST_W])
        begin
            speed_val = (quotient > aeo_pkg::SPEED_NEG_LIMIT) ? aeo_pkg::SPEED_MIN_CODE
                                                              : ('0 - q_low);
        end
        else
        begin
            speed_val = (quotient > aeo_pkg::SPEED_POS_LIMIT) ? aeo_pkg::SPEED_MAX_CODE
                                                              : q_low;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            circ_reg       <= aeo_pkg::CIRC_RESET;
            rev_reg        <= 1'b1;
            primed_reg     <= 1'b0;
            last_angle_reg <= '0;
            tick_reg       <= '0;
            prev_reg       <= '0;
            first_reg      <= 1'b0;
            angle_reg      <= '0;
            move_reg       <= '0;
            ms_reg         <= '0;
            prod_reg       <= '0;
            neg_reg        <= 1'b0;
            dist_reg       <= '0;
            delta_reg      <= '0;
            speed_reg      <= '0;
            fault_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_angle_reg  <= '0;
            out_move_reg   <= '0;
            out_tick_reg   <= '0;
            out_dist_reg   <= '0;
            out_speed_reg  <= '0;
            out_fault_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    aeo_pkg::REG_CIRCUMFERENCE: circ_reg <= cfg_data[aeo_pkg::CIRC_W-1:0];
                    aeo_pkg::REG_REVERSE:       rev_reg  <= cfg_data[0];
                    default:                    ;
                endcase
            end

            // Drop the taken word unless a new one loads in the same cycle.
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        angle_reg      <= angle_new;
                        ms_reg         <= elapsed_ms;
                        first_reg      <= !primed_reg;
                        primed_reg     <= 1'b1;
                        last_angle_reg <= angle_new;
                        if (primed_reg)
                        begin
                            move_reg <= angle_diff;
                            tick_reg <= tick_reg
                                      + aeo_pkg::TICK_W'(signed'(angle_diff));
                        end
                        else
                        begin
                            move_reg <= '0;
                        end
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= aeo_pkg::PROD_W'(tick_mag) * aeo_pkg::PROD_W'(circ_reg);
                    neg_reg   <= tick_reg[aeo_pkg::TICK_W-1] ^ rev_reg;
                    state_reg <= S_DIST;
                end
                S_DIST:
                begin
                    dist_reg  <= dist_val;
                    state_reg <= S_DELTA;
                end
                S_DELTA:
                begin
                    delta_reg <= delta_val;
                    prev_reg  <= dist_reg;
                    // Priming sample and zero elapsed time skip the divide.
                    if (first_reg || (ms_reg == '0))
                    begin
                        speed_reg <= '0;
                        fault_reg <= !first_reg;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        fault_reg <= 1'b0;
                        state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_SAT;
                    end
                end
                S_SAT:
                begin
                    speed_reg <= speed_val;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // Hold the word until the output register frees up.
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_angle_reg <= angle_reg;
                        out_move_reg  <= move_reg;
                        out_tick_reg  <= tick_reg;
                        out_dist_reg  <= dist_reg;
                        out_speed_reg <= speed_reg;
                        out_fault_reg <= fault_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign angle          = out_angle_reg;
    assign movement       = signed'(out_move_reg);
    assign position_ticks = signed'(out_tick_reg);
    assign distance_um    = aeo_pkg::DIST_OUT_W'(signed'(out_dist_reg));
    assign speed_mm_per_s = signed'(out_speed_reg);
    assign divide_fault   = out_fault_reg;

endmodule

// ===== sv/aeo_checker.sv =====
`include "absolute_encoder_odometer_defines.svh"

module aeo_checker
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic signed [aeo_pkg::SPEED_W-1:0]    speed_mm_per_s,
    input  logic                                  divide_fault
);

    // A taken sample keeps the input closed for the next cycle.
    `AEO_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)

    // No result appears in the cycle after a sample is taken when none was pending.
    `AEO_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall && !out_valid, !out_valid)

    // A fault word always reports zero speed.
    `AEO_ASSERT_NOW(a_fault_zero_speed, out_valid && divide_fault, speed_mm_per_s == '0)

    // A stalled result stays offered.
    `AEO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

endmodule

bind absolute_encoder_odometer aeo_checker u_aeo_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .speed_mm_per_s (speed_mm_per_s),
    .divide_fault   (divide_fault)
);

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    localparam logic [aeo_pkg::CFG_INDEX_W-1:0] CIRC_IDX = aeo_pkg::REG_CIRCUMFERENCE;
    localparam logic [aeo_pkg::CFG_INDEX_W-1:0] REV_IDX  = aeo_pkg::REG_REVERSE;

    typedef struct packed {
        row_kind_t                                kind;
        logic                                     pin;
        logic [aeo_pkg::ANGLE_BITS-1:0]           ang;
        logic [7-aeo_pkg::LOW_BITS:0]             junk;
        logic [aeo_pkg::ELAPSED_W-1:0]            ms;
        logic [aeo_pkg::CFG_INDEX_W-1:0]          idx;
        logic [aeo_pkg::CFG_DATA_W-1:0]           data;
        logic signed [aeo_pkg::ANGLE_BITS-1:0]    move;
        logic                                     fault;
    } step_row_t;

    typedef struct packed {
        logic [aeo_pkg::ANGLE_BITS-1:0]           angle;
        logic signed [aeo_pkg::ANGLE_BITS-1:0]    movement;
        logic signed [aeo_pkg::TICK_W-1:0]        ticks;
        logic signed [aeo_pkg::DIST_OUT_W-1:0]    distance;
        logic signed [aeo_pkg::SPEED_W-1:0]       speed;
        logic                                     fault;
    } odo_reading_t;

    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 212;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int IDLE_MODE [4]  = '{0, 77, 0, 11};
    localparam int STALL_MODE [4] = '{0, 0, 77, 11};
    localparam longint RATE_TOP    = (longint'(1) <<< (aeo_pkg::SPEED_W - 1)) - 1;
    localparam longint RATE_BOTTOM = -RATE_TOP - 1;

    // Directed words; pinned rows carry the angle, movement and fault to expect.
    localparam step_row_t PLAN [0:21] = '{
        // priming sample: elapsed time is ignored
        '{ROW_SAMPLE, 1'b1, 14'd16383, 2'b11, 16'd0,     CIRC_IDX, 24'd0, 14'd0,    1'b0},
        // forward across zero, unused low-byte bits set
        '{ROW_SAMPLE, 1'b1, 14'd0,     2'b11, 16'd1,     CIRC_IDX, 24'd0, 14'd1,    1'b0},
        // exactly half a turn counts as backward
        '{ROW_SAMPLE, 1'b1, 14'd8192,  2'b00, 16'd65535, CIRC_IDX, 24'd0, 14'h2000, 1'b0},
        '{ROW_SAMPLE, 1'b1, 14'd8255,  2'b10, 16'd0,     CIRC_IDX, 24'd0, 14'd63,   1'b1},
        '{ROW_WRITE,  1'b0, 14'd0,     2'b00, 16'd0,     CIRC_IDX, 24'hFFFFFF, 14'd0, 1'b0},
        // largest forward steps build up the tick total
        '{ROW_SAMPLE, 1'b1, 14'd62,    2'b01, 16'd1,     CIRC_IDX, 24'd0, 14'd8191, 1'b0},
        '{ROW_SAMPLE, 1'b1, 14'd8253,  2'b00, 16'd65535, CIRC_IDX, 24'd0, 14'd8191, 1'b0},
        '{ROW_SAMPLE, 1'b1, 14'd60,    2'b01, 16'd1,     CIRC_IDX, 24'd0, 14'd8191, 1'b0},
        '{ROW_SAMPLE, 1'b1, 14'd8251,  2'b00, 16'd65535, CIRC_IDX, 24'd0, 14'd8191, 1'b0},
        '{ROW_SAMPLE, 1'b1, 14'd58,    2'b01, 16'd1,     CIRC_IDX, 24'd0, 14'd8191, 1'b0},
        '{ROW_SAMPLE, 1'b1, 14'd8249,  2'b00, 16'd65535, CIRC_IDX, 24'd0, 14'd8191, 1'b0},
        '{ROW_SAMPLE, 1'b1, 14'd56,    2'b01, 16'd1,     CIRC_IDX, 24'd0, 14'd8191, 1'b0},
        '{ROW_SAMPLE, 1'b1, 14'd8247,  2'b00, 16'd1,     CIRC_IDX, 24'd0, 14'd8191, 1'b0},
        // flipping direction makes the speed saturate one way, then the other
        '{ROW_WRITE,  1'b0, 14'd0,     2'b00, 16'd0,     REV_IDX,  24'd0, 14'd0,    1'b0},
        '{ROW_SAMPLE, 1'b1, 14'd8247,  2'b00, 16'd1,     CIRC_IDX, 24'd0, 14'd0,    1'b0},
        '{ROW_WRITE,  1'b0, 14'd0,     2'b00, 16'd0,     REV_IDX,  24'd1, 14'd0,    1'b0},
        '{ROW_SAMPLE, 1'b1, 14'd8247,  2'b00, 16'd1,     CIRC_IDX, 24'd0, 14'd0,    1'b0},
        // zero circumference: distance collapses to zero
        '{ROW_WRITE,  1'b0, 14'd0,     2'b00, 16'd0,     CIRC_IDX, 24'd0, 14'd0,    1'b0},
        '{ROW_SAMPLE, 1'b1, 14'd8247,  2'b00, 16'd65535, CIRC_IDX, 24'd0, 14'd0,    1'b0},
        '{ROW_SAMPLE, 1'b1, 14'd0,     2'b11, 16'd7,     CIRC_IDX, 24'd0, 14'd8137, 1'b0},
        '{ROW_WRITE,  1'b0, 14'd0,     2'b00, 16'd0,     CIRC_IDX, 24'd1, 14'd0,    1'b0},
        '{ROW_SAMPLE, 1'b1, 14'd16383, 2'b10, 16'd3,     CIRC_IDX, 24'd0, 14'h3FFF, 1'b0}
    };

    logic                                   clk;
    logic                                   rst_n      = 1'b0;
    logic                                   cfg_we     = 1'b0;
    logic [aeo_pkg::CFG_INDEX_W-1:0]        cfg_index  = '0;
    logic [aeo_pkg::CFG_DATA_W-1:0]         cfg_data   = '0;
    logic                                   in_valid   = 1'b0;
    logic                                   in_stall;
    logic [7:0]                             angle_high = '0;
    logic [7:0]                             angle_low  = '0;
    logic [aeo_pkg::ELAPSED_W-1:0]          elapsed_ms = '0;
    logic                                   out_valid;
    logic                                   out_stall  = 1'b0;
    logic [aeo_pkg::ANGLE_BITS-1:0]         angle;
    logic signed [aeo_pkg::ANGLE_BITS-1:0]  movement;
    logic signed [aeo_pkg::TICK_W-1:0]      position_ticks;
    logic signed [aeo_pkg::DIST_OUT_W-1:0]  distance_um;
    logic signed [aeo_pkg::SPEED_W-1:0]     speed_mm_per_s;
    logic                                   divide_fault;

    // odometer shadow state and settings
    logic [aeo_pkg::ANGLE_BITS-1:0]         last_angle_q = '0;
    logic [aeo_pkg::TICK_W-1:0]             tick_q       = '0;
    longint                                 prev_travel_q = 0;
    logic                                   primed_q     = 1'b0;
    logic [aeo_pkg::CIRC_W-1:0]             circ_q       = aeo_pkg::CIRC_RESET;
    logic                                   rev_q        = 1'b1;

    odo_reading_t                  pending_readings [$];
    int                            mismatch_count = 0;
    int                            result_count   = 0;
    int                            quiet_cycles   = 0;
    int                            idle_pct       = 0;
    int                            stall_pct      = 0;

    absolute_encoder_odometer dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .angle_high     (angle_high),
        .angle_low      (angle_low),
        .elapsed_ms     (elapsed_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .angle          (angle),
        .movement       (movement),
        .position_ticks (position_ticks),
        .distance_um    (distance_um),
        .speed_mm_per_s (speed_mm_per_s),
        .divide_fault   (divide_fault)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint scaled_travel(input logic [aeo_pkg::TICK_W-1:0] t);
        longint prod;
        prod = longint'(signed'(t)) * longint'(circ_q)
             / longint'(1 << aeo_pkg::ANGLE_BITS);
        return rev_q ? -prod : prod;
    endfunction

    function automatic odo_reading_t advance_odometer(
        input logic [aeo_pkg::ANGLE_BITS-1:0] ang,
        input logic [aeo_pkg::ELAPSED_W-1:0]  ms);
        odo_reading_t r;
        longint       travel;
        longint       rate;
        r       = '0;
        r.angle = ang;
        if (!primed_q)
        begin
            primed_q = 1'b1;
            travel   = scaled_travel(tick_q);
        end
        else
        begin
            // 14-bit wrap gives the signed short-way change directly
            r.movement = ang - last_angle_q;
            tick_q     = tick_q
                       + {{(aeo_pkg::TICK_W-aeo_pkg::ANGLE_BITS){r.movement[aeo_pkg::ANGLE_BITS-1]}},
                          r.movement};
            travel     = scaled_travel(tick_q);
            if (ms == '0)
                r.fault = 1'b1;
            else
            begin
                rate = (travel - prev_travel_q) / longint'(ms);
                if (rate > RATE_TOP)
                    rate = RATE_TOP;
                if (rate < RATE_BOTTOM)
                    rate = RATE_BOTTOM;
                r.speed = rate[aeo_pkg::SPEED_W-1:0];
            end
        end
        last_angle_q  = ang;
        prev_travel_q = travel;
        r.ticks       = tick_q;
        r.distance    = travel[aeo_pkg::DIST_OUT_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH %s", msg);
        mismatch_count++;
    endtask

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic feed_sample(input logic [aeo_pkg::ANGLE_BITS-1:0] ang,
                               input logic [7-aeo_pkg::LOW_BITS:0] junk,
                               input logic [aeo_pkg::ELAPSED_W-1:0] ms,
                               output odo_reading_t predicted);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        angle_high <= ang[aeo_pkg::ANGLE_BITS-1 -: 8];
        angle_low  <= {junk, ang[aeo_pkg::LOW_BITS-1:0]};
        elapsed_ms <= ms;
        // hold the word until the block takes it
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = advance_odometer(ang, ms);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [aeo_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [aeo_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == aeo_pkg::REG_CIRCUMFERENCE)
            circ_q = data;
        else
            rev_q = data[0];
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        odo_reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_readings.size() == 0)
                flag_mismatch($sformatf("result %0d arrived with nothing pending",
                                        result_count));
            else
            begin
                want = pending_readings.pop_front();
                if (angle !== want.angle)
                    flag_mismatch($sformatf("result %0d angle got %0d expected %0d",
                                            result_count, angle, want.angle));
                if (movement !== want.movement)
                    flag_mismatch($sformatf("result %0d movement got %0d expected %0d",
                                            result_count, movement, want.movement));
                if (position_ticks !== want.ticks)
                    flag_mismatch($sformatf("result %0d position_ticks got %0d expected %0d",
                                            result_count, position_ticks, want.ticks));
                if (distance_um !== want.distance)
                    flag_mismatch($sformatf("result %0d distance_um got %0d expected %0d",
                                            result_count, distance_um, want.distance));
                if (speed_mm_per_s !== want.speed)
                    flag_mismatch($sformatf("result %0d speed got %0d expected %0d",
                                            result_count, speed_mm_per_s, want.speed));
                if (divide_fault !== want.fault)
                    flag_mismatch($sformatf("result %0d divide_fault got %0b expected %0b",
                                            result_count, divide_fault, want.fault));
            end
            result_count++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        odo_reading_t                   want;
        logic [aeo_pkg::ANGLE_BITS-1:0] cur_angle;
        logic [aeo_pkg::ANGLE_BITS-1:0] delta;
        logic [aeo_pkg::ELAPSED_W-1:0]  ms;
        logic [aeo_pkg::CIRC_W-1:0]     circ;
        int                             pick;
        int                             p;
        int                             n;
        cur_angle = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[i])
        begin
            if (PLAN[i].kind == ROW_WRITE)
            begin
                settle();
                write_reg(PLAN[i].idx, PLAN[i].data);
            end
            else
            begin
                feed_sample(PLAN[i].ang, PLAN[i].junk, PLAN[i].ms, want);
                if (PLAN[i].pin)
                begin
                    want.angle    = PLAN[i].ang;
                    want.movement = PLAN[i].move;
                    want.fault    = PLAN[i].fault;
                    if (PLAN[i].fault)
                        want.speed = '0;
                end
                pending_readings.push_back(want);
                cur_angle = PLAN[i].ang;
            end
        end

        for (p = 0; p < PHASES; p++)
        begin
            settle();
            case (p % 4)
                0:       circ = '1;
                1:       circ = 24'd1;
                2:       circ = aeo_pkg::CIRC_W'($urandom);
                default: circ = aeo_pkg::CIRC_W'($urandom_range(2000000, 1000000));
            endcase
            if (p == 5)
                circ = '0;
            write_reg(aeo_pkg::REG_CIRCUMFERENCE, circ);
            write_reg(aeo_pkg::REG_REVERSE, aeo_pkg::CFG_DATA_W'(p[0] ^ p[2]));
            idle_pct  = IDLE_MODE[p % 4];
            stall_pct <= STALL_MODE[p % 4];
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // mostly small rotations, some near half a turn, the rest anywhere
                pick = $urandom_range(99);
                if (pick < 50)
                    delta = aeo_pkg::ANGLE_BITS'($urandom_range(400))
                          - aeo_pkg::ANGLE_BITS'(200);
                else if (pick < 54)
                    delta = aeo_pkg::ANGLE_BITS'(8191);
                else if (pick < 57)
                    delta = aeo_pkg::ANGLE_BITS'(8192);
                else if (pick < 60)
                    delta = aeo_pkg::ANGLE_BITS'(8193);
                else
                    delta = aeo_pkg::ANGLE_BITS'($urandom);
                cur_angle = cur_angle + delta;
                pick = $urandom_range(15);
                if (pick == 0)
                    ms = '0;
                else if (pick == 1)
                    ms = '1;
                else if (pick < 5)
                    ms = aeo_pkg::ELAPSED_W'($urandom);
                else
                    ms = aeo_pkg::ELAPSED_W'($urandom_range(50, 1));
                feed_sample(cur_angle, (7-aeo_pkg::LOW_BITS+1)'($urandom), ms, want);
                pending_readings.push_back(want);
            end
        end

        settle();
        repeat (60) @(posedge clk);
        if (pending_readings.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_readings.size()));
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
